[rtl/spoe_pkg.sv]
// spoe_pkg: item types, opcodes, status codes and state encoding for the slot pool
// with oldest eviction. Depends on nothing; imported by slot_pool_oldest_eviction.
package spoe_pkg;

  // fixed field width of a slot index on the ports
  localparam int SLOT_W = 9;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic ST_OK         = 1'b0;
  localparam logic ST_NOT_ACTIVE = 1'b1;

  // request item
  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              evicted;
    logic              status;
  } out_item_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

endpackage

[rtl/slot_pool_oldest_eviction.sv]
// slot_pool_oldest_eviction: slot allocator with LIFO free list and age-ordered
// active list, links held in two single-port-write synchronous memories; uses spoe_pkg.
// Timing: the request is captured and the link memories read at acceptance; in S_BUSY
// the result is computed and registered. A new item is taken only in S_IDLE; the
// second link write retires in the next idle cycle with read forwarding.
// Reset: synchronous, no clearing pass; untouched slots are tracked by a fill count.
module slot_pool_oldest_eviction #(
  parameter int SLOTS = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  spoe_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output spoe_pkg::out_item_t  out_data
);
  import spoe_pkg::*;

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = IW + 1;
  localparam int CMP_W = (CW > SLOT_W) ? CW : SLOT_W;

  // link memories: newer link, and {active, older link}
  logic [IW-1:0] newer_mem [SLOTS];
  logic [IW:0]   older_mem [SLOTS];

  // controller and list state
  state_t        state_r, state_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] stack_cnt_r, stack_cnt_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] newest_r, newest_nxt;
  logic [IW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] active_cnt_r, active_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // captured request
  logic              op_r, op_nxt;
  logic [SLOT_W-1:0] slot_in_r, slot_in_nxt;
  logic              evict_r, evict_nxt;
  logic              fresh_pop_r, fresh_pop_nxt;

  // deferred second writes
  logic          pend_a_vld_r, pend_a_vld_nxt;
  logic [IW-1:0] pend_a_addr_r, pend_a_addr_nxt;
  logic [IW-1:0] pend_a_data_r, pend_a_data_nxt;
  logic          pend_b_vld_r, pend_b_vld_nxt;
  logic [IW-1:0] pend_b_addr_r, pend_b_addr_nxt;
  logic [IW:0]   pend_b_data_r, pend_b_data_nxt;

  // memory ports
  logic          a_we, b_we;
  logic [IW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [IW-1:0] a_wdata, a_rd_r, a_data;
  logic [IW:0]   b_wdata, b_rd_r, b_data;

  // forwarding of the write that retires together with a read
  logic          fwd_a_r, fwd_b_r;
  logic [IW-1:0] fwd_a_data_r;
  logic [IW:0]   fwd_b_data_r;

  logic          evict_now;
  logic [IW-1:0] in_slot;

  assign busy      = (state_r == S_BUSY);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_slot   = IW'(in_data.slot_in);
  assign evict_now = (stack_cnt_r == '0) && (fresh_r == CW'(SLOTS));

  // read addresses follow the request being accepted
  always_comb begin
    b_raddr = in_slot;
    if (in_data.opcode == OP_FREE) begin
      a_raddr = in_slot;
    end else if (evict_now) begin
      a_raddr = oldest_r;
    end else begin
      a_raddr = free_head_r;
    end
  end

  // newer link memory
  always_ff @(posedge clk) begin
    if (a_we) begin
      newer_mem[a_waddr] <= a_wdata;
    end
    a_rd_r <= newer_mem[a_raddr];
  end

  // older link and active bit memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      older_mem[b_waddr] <= b_wdata;
    end
    b_rd_r <= older_mem[b_raddr];
  end

  // forward a deferred write that lands on the address being read
  always_ff @(posedge clk) begin
    fwd_a_r      <= pend_a_vld_r && (pend_a_addr_r == a_raddr);
    fwd_a_data_r <= pend_a_data_r;
    fwd_b_r      <= pend_b_vld_r && (pend_b_addr_r == b_raddr);
    fwd_b_data_r <= pend_b_data_r;
  end

  assign a_data = fwd_a_r ? fwd_a_data_r : a_rd_r;
  assign b_data = fwd_b_r ? fwd_b_data_r : b_rd_r;

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      stack_cnt_r  <= '0;
      fresh_r      <= '0;
      newest_r     <= '0;
      oldest_r     <= '0;
      active_cnt_r <= '0;
      out_valid_r  <= 1'b0;
      pend_a_vld_r <= 1'b0;
      pend_b_vld_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      stack_cnt_r  <= stack_cnt_nxt;
      fresh_r      <= fresh_nxt;
      newest_r     <= newest_nxt;
      oldest_r     <= oldest_nxt;
      active_cnt_r <= active_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_a_vld_r <= pend_a_vld_nxt;
      pend_b_vld_r <= pend_b_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    slot_in_r     <= slot_in_nxt;
    evict_r       <= evict_nxt;
    fresh_pop_r   <= fresh_pop_nxt;
    out_data_r    <= out_data_nxt;
    pend_a_addr_r <= pend_a_addr_nxt;
    pend_a_data_r <= pend_a_data_nxt;
    pend_b_addr_r <= pend_b_addr_nxt;
    pend_b_data_r <= pend_b_data_nxt;
  end

  // next state, list update and memory writes
  always_comb begin
    logic [IW-1:0] grant;
    logic [IW-1:0] req_slot;
    logic [IW-1:0] old_lnk;
    logic          slot_ok;

    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    stack_cnt_nxt   = stack_cnt_r;
    fresh_nxt       = fresh_r;
    newest_nxt      = newest_r;
    oldest_nxt      = oldest_r;
    active_cnt_nxt  = active_cnt_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    op_nxt          = op_r;
    slot_in_nxt     = slot_in_r;
    evict_nxt       = evict_r;
    fresh_pop_nxt   = fresh_pop_r;
    pend_a_vld_nxt  = 1'b0;
    pend_a_addr_nxt = pend_a_addr_r;
    pend_a_data_nxt = pend_a_data_r;
    pend_b_vld_nxt  = 1'b0;
    pend_b_addr_nxt = pend_b_addr_r;
    pend_b_data_nxt = pend_b_data_r;
    a_we            = 1'b0;
    a_waddr         = pend_a_addr_r;
    a_wdata         = pend_a_data_r;
    b_we            = 1'b0;
    b_waddr         = pend_b_addr_r;
    b_wdata         = pend_b_data_r;

    req_slot = IW'(slot_in_r);
    old_lnk  = b_data[IW-1:0];
    grant    = free_head_r;
    slot_ok  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // deferred writes of the previous item retire here
        a_we = pend_a_vld_r;
        b_we = pend_b_vld_r;
        if (start) begin
          state_nxt     = S_BUSY;
          op_nxt        = in_data.opcode;
          slot_in_nxt   = in_data.slot_in;
          evict_nxt     = evict_now;
          fresh_pop_nxt = (stack_cnt_r == '0);
        end
      end

      S_BUSY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (op_r == OP_ALLOC) begin
          // pick the slot: reclaim oldest, take an untouched slot, or pop the stack
          if (evict_r) begin
            grant      = oldest_r;
            oldest_nxt = a_data;
          end else if (fresh_pop_r) begin
            grant          = fresh_r[IW-1:0];
            fresh_nxt      = fresh_r + CW'(1);
            active_cnt_nxt = active_cnt_r + CW'(1);
          end else begin
            grant          = free_head_r;
            free_head_nxt  = a_data;
            stack_cnt_nxt  = stack_cnt_r - CW'(1);
            active_cnt_nxt = active_cnt_r + CW'(1);
          end
          // link as newest
          a_we    = 1'b1;
          a_waddr = grant;
          a_wdata = grant;
          b_we    = 1'b1;
          b_waddr = grant;
          b_wdata = {1'b1, newest_r};
          if (active_cnt_r != '0) begin
            pend_a_vld_nxt  = 1'b1;
            pend_a_addr_nxt = newest_r;
            pend_a_data_nxt = grant;
          end else begin
            oldest_nxt = grant;
          end
          newest_nxt            = grant;
          out_data_nxt.slot_out = SLOT_W'(grant);
          out_data_nxt.evicted  = evict_r;
          out_data_nxt.status   = ST_OK;
        end else begin
          // free: slot must be in range, touched and marked active
          slot_ok = (CMP_W'(slot_in_r) < CMP_W'(SLOTS)) &&
                    ({1'b0, req_slot} < fresh_r) && b_data[IW];
          out_data_nxt.slot_out = slot_in_r;
          out_data_nxt.evicted  = 1'b0;
          out_data_nxt.status   = slot_ok ? ST_OK : ST_NOT_ACTIVE;
          if (slot_ok) begin
            // unlink from the age list
            if (req_slot == oldest_r) begin
              oldest_nxt = a_data;
            end else begin
              a_we    = 1'b1;
              a_waddr = old_lnk;
              a_wdata = a_data;
            end
            if (req_slot == newest_r) begin
              newest_nxt = old_lnk;
            end else begin
              b_we    = 1'b1;
              b_waddr = a_data;
              b_wdata = {1'b1, old_lnk};
            end
            // push onto the free stack
            pend_a_vld_nxt  = 1'b1;
            pend_a_addr_nxt = req_slot;
            pend_a_data_nxt = free_head_r;
            pend_b_vld_nxt  = 1'b1;
            pend_b_addr_nxt = req_slot;
            pend_b_data_nxt = {1'b0, old_lnk};
            free_head_nxt   = req_slot;
            stack_cnt_nxt   = stack_cnt_r + CW'(1);
            active_cnt_nxt  = active_cnt_r - CW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
